>>> design/psp_pkg.sv
`default_nettype none
package psp_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int MAX_RESULTS = 64;
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int NW = $clog2(MAX_RESULTS + 1);
	localparam int QW = 23;
	localparam int IN_W = 200;
	localparam int OUT_W = 176;
	localparam int RES_W = 171;

	typedef logic [3:0] op_t;
	localparam op_t OP_NONE        = 4'd0;
	localparam op_t OP_INSERT      = 4'd1;
	localparam op_t OP_EMPTY       = 4'd2;
	localparam op_t OP_REQ_START   = 4'd3;
	localparam op_t OP_SCAN        = 4'd4;
	localparam op_t OP_SHIFT       = 4'd5;
	localparam op_t OP_FIT         = 4'd6;
	localparam op_t OP_SPLIT       = 4'd7;
	localparam op_t OP_NOFIT_EMPTY = 4'd8;
	localparam op_t OP_NOFIT_HELD  = 4'd9;

	typedef logic [1:0] cat_t;
	localparam cat_t CAT_FIT   = 2'd0;
	localparam cat_t CAT_SPLIT = 2'd1;
	localparam cat_t CAT_NOFIT = 2'd2;

	typedef struct packed {
		logic [61:0] stream;
		logic [61:0] offset;
		logic [15:0] payload;
		logic [4:0]  header;
		logic [31:0] time_tick;
		logic        retx;
		logic        fin;
	} frame_t;

	typedef struct packed {
		logic [QW-1:0] pending;
		logic          empty;
		logic          split;
		logic          fin;
		logic [4:0]    header;
		logic [15:0]   payload;
		logic [61:0]   offset;
		logic [61:0]   stream;
	} result_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic shift_done;
		cat_t cat;
		logic cont;
		logic count_zero;
		logic budget_zero;
	} status_t;

	// true when a leaves strictly before b
	function automatic logic goes_first(input frame_t a, input frame_t b);
		logic r;
		if (a.retx != b.retx) r = a.retx;
		else if (!a.retx && a.time_tick != b.time_tick) r = a.time_tick < b.time_tick;
		else if (a.stream != b.stream) r = a.stream < b.stream;
		else r = a.offset < b.offset;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> design/psp_datapath.sv
`default_nettype none
module psp_datapath import psp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cmd_t             cmd,
	output status_t               sts,
	input  wire logic [IN_W-1:0]  in_data,
	output result_t               res,
	output logic                  res_last
);

	frame_t mem_q [QUEUE_DEPTH];
	frame_t rd_q;
	frame_t best_q;
	frame_t in_frame;
	logic [AW-1:0] best_idx_q;
	logic [CW-1:0] count_q, ra_q, sr_q, sr_nxt;
	logic [QW-1:0] queued_q;
	logic [15:0]   budget_q, used_q, in_budget;
	logic [NW-1:0] n_q;
	logic          valid_s1, wv_s1;
	logic [AW-1:0] idx_s1, wa_s1;
	result_t       res_q;
	logic          res_last_q;

	logic [16:0] size_best, in_size, rest_size;
	logic [17:0] sum;
	logic [15:0] rem, head_len, rest_payload;
	logic        fits, hdr_only, cont, shift_rd;
	cat_t        cat;

	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	frame_t        wr_data, rest;

	assign in_frame.stream    = in_data[61:0];
	assign in_frame.offset    = in_data[123:62];
	assign in_frame.payload   = in_data[139:124];
	assign in_frame.header    = in_data[144:140];
	assign in_frame.fin       = in_data[145];
	assign in_frame.retx      = in_data[146];
	assign in_frame.time_tick = in_data[178:147];
	assign in_budget          = in_data[194:179];

	assign in_size   = {1'b0, in_frame.payload} + {12'd0, in_frame.header};
	assign size_best = {1'b0, best_q.payload} + {12'd0, best_q.header};
	assign sum       = {2'b0, used_q} + {1'b0, size_best};
	assign fits      = sum <= {2'b0, budget_q};
	assign rem       = budget_q - used_q;
	assign hdr_only  = rem <= {11'd0, best_q.header};
	assign head_len  = rem - {11'd0, best_q.header};
	assign rest_payload = best_q.payload - head_len;
	assign rest_size = {1'b0, rest_payload} + {12'd0, best_q.header};
	assign cont = (count_q != '0) && (sum[15:0] < budget_q) && (n_q < NW'(MAX_RESULTS - 1));

	always_comb begin
		rest = best_q;
		rest.offset = best_q.offset + {46'd0, head_len};
		rest.payload = rest_payload;
	end

	always_comb begin
		if (fits) cat = CAT_FIT;
		else if (hdr_only) cat = CAT_NOFIT;
		else cat = CAT_SPLIT;
	end

	assign sr_nxt   = sr_q + CW'(1);
	assign shift_rd = sr_nxt < count_q;

	assign sts.scan_done   = (ra_q == count_q) && !valid_s1;
	assign sts.shift_done  = !shift_rd && !wv_s1;
	assign sts.cat         = cat;
	assign sts.cont        = cont;
	assign sts.count_zero  = count_q == '0;
	assign sts.budget_zero = in_budget == '0;

	// memory port selection
	always_comb begin
		wr_en = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = in_frame;
		rd_en = 1'b0;
		rd_addr = ra_q[AW-1:0];
		unique case (cmd.op)
			OP_INSERT: wr_en = count_q < CW'(QUEUE_DEPTH);
			OP_SPLIT: begin
				wr_en = 1'b1;
				wr_data = rest;
			end
			OP_NOFIT_EMPTY, OP_NOFIT_HELD: begin
				wr_en = 1'b1;
				wr_data = best_q;
			end
			OP_SCAN: rd_en = ra_q < count_q;
			OP_SHIFT: begin
				rd_en = shift_rd;
				rd_addr = sr_nxt[AW-1:0];
				wr_en = wv_s1;
				wr_addr = wa_s1;
				wr_data = rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_SCAN && valid_s1 && (idx_s1 == '0 || goes_first(rd_q, best_q))) begin
			best_q <= rd_q;
			best_idx_q <= idx_s1;
		end
		idx_s1 <= ra_q[AW-1:0];
		wa_s1 <= sr_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			queued_q <= '0;
			budget_q <= '0;
			used_q <= '0;
			n_q <= '0;
			ra_q <= '0;
			sr_q <= '0;
			valid_s1 <= 1'b0;
			wv_s1 <= 1'b0;
		end else begin
			ra_q <= '0;
			valid_s1 <= 1'b0;
			wv_s1 <= 1'b0;
			unique case (cmd.op)
				OP_INSERT: begin
					if (count_q < CW'(QUEUE_DEPTH)) begin
						count_q <= count_q + CW'(1);
						queued_q <= queued_q + QW'(in_size);
					end
				end
				OP_REQ_START: begin
					budget_q <= in_budget;
					used_q <= '0;
					n_q <= '0;
				end
				OP_SCAN: begin
					if (ra_q < count_q) begin
						ra_q <= ra_q + CW'(1);
						valid_s1 <= 1'b1;
					end else begin
						ra_q <= ra_q;
					end
					sr_q <= {{(CW-AW){1'b0}}, best_idx_q};
				end
				OP_SHIFT: begin
					if (shift_rd) begin
						sr_q <= sr_nxt;
						wv_s1 <= 1'b1;
					end else if (!wv_s1) begin
						count_q <= count_q - CW'(1);
						queued_q <= queued_q - QW'(size_best);
					end
				end
				OP_FIT: begin
					used_q <= sum[15:0];
					n_q <= n_q + NW'(1);
				end
				OP_SPLIT: begin
					n_q <= n_q + NW'(1);
					count_q <= count_q + CW'(1);
					queued_q <= queued_q + QW'(rest_size);
				end
				OP_NOFIT_EMPTY, OP_NOFIT_HELD: begin
					count_q <= count_q + CW'(1);
					queued_q <= queued_q + QW'(size_best);
				end
				default: ;
			endcase
		end
	end

	// result register: pending, empty, split, fin, header, payload, offset, stream
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_EMPTY: begin
				res_q <= {queued_q, 1'b1, 147'd0};
				res_last_q <= 1'b1;
			end
			OP_NOFIT_EMPTY: begin
				res_q <= {queued_q + QW'(size_best), 1'b1, 147'd0};
				res_last_q <= 1'b1;
			end
			OP_NOFIT_HELD: res_last_q <= 1'b1;
			OP_FIT: begin
				res_q <= {queued_q, 1'b0, 1'b0, best_q.fin, best_q.header,
					best_q.payload, best_q.offset, best_q.stream};
				res_last_q <= !cont;
			end
			OP_SPLIT: begin
				res_q <= {queued_q + QW'(rest_size), 1'b0, 1'b1, 1'b0, best_q.header,
					head_len, best_q.offset, best_q.stream};
				res_last_q <= 1'b1;
			end
			default: ;
		endcase
	end

	assign res = res_q;
	assign res_last = res_last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH)) else $error("store count overflow");
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_INSERT && count_q < CW'(QUEUE_DEPTH) |=>
		count_q == $past(count_q) + CW'(1)) else $error("insert lost");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= budget_q) else $error("budget overrun");
`endif

endmodule
`default_nettype wire

>>> design/psp_ctrl.sv
`default_nettype none
module psp_ctrl import psp_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    in_kind,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire status_t sts,
	output cmd_t         cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_SHIFT  = 3'd2;
	localparam logic [2:0] ST_DECIDE = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;

	logic [2:0] state_q, state_d;
	logic       held_q, held_d;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = state_q == ST_OUT;

	always_comb begin
		state_d = state_q;
		held_d = held_q;
		cmd.op = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (!in_kind) begin
						cmd.op = OP_INSERT;
					end else if (sts.count_zero || sts.budget_zero) begin
						cmd.op = OP_EMPTY;
						state_d = ST_OUT;
					end else begin
						cmd.op = OP_REQ_START;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.op = OP_SCAN;
				if (sts.scan_done) state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				cmd.op = OP_SHIFT;
				if (sts.shift_done) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				priority if (sts.cat == CAT_NOFIT) begin
					cmd.op = held_q ? OP_NOFIT_HELD : OP_NOFIT_EMPTY;
					held_d = 1'b0;
					state_d = ST_OUT;
				end else if (held_q) begin
					// release the previous frame first; it is not the last
					state_d = ST_OUT;
				end else if (sts.cat == CAT_SPLIT) begin
					cmd.op = OP_SPLIT;
					state_d = ST_OUT;
				end else begin
					cmd.op = OP_FIT;
					if (sts.cont) begin
						held_d = 1'b1;
						state_d = ST_SCAN;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_OUT: begin
				if (out_ready) begin
					held_d = 1'b0;
					state_d = held_q ? ST_DECIDE : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q <= 1'b0;
		end else begin
			state_q <= state_d;
			held_q <= held_d;
		end
	end

endmodule
`default_nettype wire

>>> design/priority_segment_packer_core.sv
`default_nettype none
// Transmit scheduler holding up to 64 stream frames in a single-port-write
// store. An insert (tuser=0) stores a frame unless the store is full.
// A request (tuser=1) pops frames in priority order: each pop scans all
// N stored entries through the memory read port, then closes the gap
// behind the chosen entry one entry per cycle, then takes a decision step.
// Each result waits at the output until the receiver takes it.
// Results leave through a registered master port; tlast marks the final result
// of a request.
module priority_segment_packer_core import psp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// stream_id, stream_offset, payload_bytes, header_bytes, fin_flag,
	// is_retransmit, enqueue_time, byte_budget, zero pad
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	// kind
	input  wire logic             s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// out_stream_id, out_offset, out_payload, out_header, out_fin,
	// was_split, empty_segment, pending_bytes, zero pad
	output logic [OUT_W-1:0]      m_axis_tdata,
	output logic                  m_axis_tlast
);

	cmd_t    cmd;
	status_t sts;
	result_t res;

	psp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_kind   (s_axis_tuser),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	psp_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (s_axis_tdata),
		.res      (res),
		.res_last (m_axis_tlast)
	);

	assign m_axis_tdata = {{(OUT_W-RES_W){1'b0}}, res};

endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;
	import psp_pkg::*;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [OUT_W-1:0] m_axis_tdata;
	logic m_axis_tlast;
	logic s_axis_tready_seen;

	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;
	localparam int WATCHDOG_LIMIT = 200000;

	typedef struct {
		logic kind;
		frame_t fr;
		logic [15:0] budget;
	} txn_t;

	typedef struct {
		result_t res;
		logic last;
	} seg_t;

	priority_segment_packer_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	txn_t pending_txns[$];
	seg_t expected_segs[$];
	frame_t sched_store[$];
	logic [22:0] sched_bytes;
	int mismatches;
	int idle_cycles;
	bit stim_done;
	bit hold_off;
	int burst_left, gap_left, stall_left;
	txn_t cur;

	function automatic logic leaves_first(frame_t a, frame_t b);
		if (a.retx != b.retx) return a.retx;
		if (!a.retx && a.time_tick != b.time_tick) return a.time_tick < b.time_tick;
		if (a.stream != b.stream) return a.stream < b.stream;
		return a.offset < b.offset;
	endfunction

	function automatic void store_frame(frame_t f);
		if (sched_store.size() >= QUEUE_DEPTH) return;
		sched_store.push_back(f);
		sched_bytes = sched_bytes + 23'(f.payload) + 23'(f.header);
	endfunction

	function automatic frame_t take_best();
		int best;
		frame_t f;
		best = 0;
		for (int i = 1; i < sched_store.size(); i++)
			if (leaves_first(sched_store[i], sched_store[best])) best = i;
		f = sched_store[best];
		sched_store.delete(best);
		sched_bytes = sched_bytes - 23'(f.payload) - 23'(f.header);
		return f;
	endfunction

	function automatic void emit_seg(frame_t f, logic split, logic empty);
		seg_t s;
		s.res = '0;
		if (!empty) begin
			s.res.stream = f.stream;
			s.res.offset = f.offset;
			s.res.payload = f.payload;
			s.res.header = f.header;
			s.res.fin = f.fin;
		end
		s.res.split = split;
		s.res.empty = empty;
		s.res.pending = sched_bytes;
		s.last = 1'b0;
		expected_segs.push_back(s);
	endfunction

	function automatic void schedule_txn(txn_t t);
		int n, used, budget, sz, head_len;
		frame_t f, rest;
		if (t.kind == KIND_INSERT) begin
			store_frame(t.fr);
			return;
		end
		n = 0;
		used = 0;
		budget = t.budget;
		while (sched_store.size() > 0 && used < budget && n < MAX_RESULTS) begin
			f = take_best();
			sz = f.payload + f.header;
			if (used + sz <= budget) begin
				used += sz;
				emit_seg(f, 1'b0, 1'b0);
				n++;
				continue;
			end
			if (budget - used <= f.header) begin
				store_frame(f);
				break;
			end
			head_len = budget - used - f.header;
			rest = f;
			rest.offset = f.offset + 62'(head_len);
			rest.payload = f.payload - 16'(head_len);
			store_frame(rest);
			f.payload = 16'(head_len);
			f.fin = 1'b0;
			emit_seg(f, 1'b1, 1'b0);
			n++;
			break;
		end
		if (n == 0) begin
			f = '0;
			emit_seg(f, 1'b0, 1'b1);
		end
		expected_segs[$].last = 1'b1;
	endfunction

	function automatic logic [IN_W-1:0] pack_txn(txn_t t);
		logic [IN_W-1:0] d;
		d = '0;
		d[61:0] = t.fr.stream;
		d[123:62] = t.fr.offset;
		d[139:124] = t.fr.payload;
		d[144:140] = t.fr.header;
		d[145] = t.fr.fin;
		d[146] = t.fr.retx;
		d[178:147] = t.fr.time_tick;
		d[194:179] = t.budget;
		return d;
	endfunction

	function automatic logic [61:0] rand62();
		return {$urandom(), $urandom()};
	endfunction

	task automatic add_insert(logic [61:0] sid, logic [61:0] off, logic [15:0] pay,
			logic [4:0] hdr, logic fin, logic retx, logic [31:0] tick);
		txn_t t;
		t.kind = KIND_INSERT;
		t.fr.stream = sid;
		t.fr.offset = off;
		t.fr.payload = pay;
		t.fr.header = hdr;
		t.fr.fin = fin;
		t.fr.retx = retx;
		t.fr.time_tick = tick;
		t.budget = 16'($urandom());
		pending_txns.push_back(t);
	endtask

	task automatic add_request(logic [15:0] budget);
		txn_t t;
		t.kind = KIND_REQUEST;
		t.fr.stream = rand62();
		t.fr.offset = rand62();
		t.fr.payload = 16'($urandom());
		t.fr.header = 5'($urandom());
		t.fr.fin = 1'($urandom());
		t.fr.retx = 1'($urandom());
		t.fr.time_tick = $urandom();
		t.budget = budget;
		pending_txns.push_back(t);
	endtask

	task automatic add_random_insert(int pay_max);
		add_insert($urandom_range(0, 3) == 0 ? rand62() : 62'($urandom_range(0, 3)),
			$urandom_range(0, 7) == 0 ? rand62() : 62'($urandom_range(0, 4000)),
			16'($urandom_range(0, pay_max)), 5'($urandom_range(1, 25)),
			1'($urandom()), 1'($urandom_range(0, 3) == 0),
			$urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 20));
	endtask

	// driver: bursts of offers separated by random gaps
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!s_axis_tvalid || s_axis_tready_seen) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_txns.size() > 0) begin
				cur = pending_txns.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= pack_txn(cur);
				s_axis_tuser <= cur.kind;
				if (burst_left <= 0) begin
					burst_left <= $urandom_range(1, 20);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// acceptance observed at the rising edge, consumed by the driver at the falling edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tready_seen <= 1'b0;
		end else begin
			s_axis_tready_seen <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) schedule_txn(cur);
		end
	end

	// receiver stall pattern, with a long hold-off when requested
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left <= 0;
		end else if (hold_off) begin
			m_axis_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 12);
		end
	end

	// monitor
	always @(posedge clk) begin
		seg_t e;
		result_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[RES_W-1:0];
			if (expected_segs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h last %b", got, m_axis_tlast);
			end else begin
				e = expected_segs.pop_front();
				if (got !== e.res || m_axis_tlast !== e.last
						|| m_axis_tdata[OUT_W-1:RES_W] !== '0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp sid %h off %h pay %0d hdr %0d fin %b split %b empty %b pend %0d last %b",
							e.res.stream, e.res.offset, e.res.payload, e.res.header,
							e.res.fin, e.res.split, e.res.empty, e.res.pending, e.last);
						$display("          got sid %h off %h pay %0d hdr %0d fin %b split %b empty %b pend %0d last %b",
							got.stream, got.offset, got.payload, got.header,
							got.fin, got.split, got.empty, got.pending, m_axis_tlast);
					end
				end
			end
		end
	end

	// watchdog: cycles with no transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| hold_off)
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		mismatches = 0;
		idle_cycles = 0;
		hold_off = 1'b0;
		stim_done = 1'b0;
		sched_bytes = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n = 1'b1;

		// directed: empty store, zero budget, ordering, split, header-only miss
		add_request(16'd100);
		add_insert(62'h3FFF_FFFF_FFFF_FFFF, 62'h3FFF_FFFF_FFFF_FFF0, 16'd40, 5'd25,
			1'b1, 1'b0, 32'hFFFF_FFFF);
		add_insert(62'd0, 62'd0, 16'd0, 5'd1, 1'b0, 1'b0, 32'd0);
		add_insert(62'd5, 62'd10, 16'hFFFF, 5'd3, 1'b1, 1'b1, 32'd7);
		add_insert(62'd5, 62'd2, 16'd10, 5'd3, 1'b0, 1'b1, 32'd9);
		add_insert(62'd2, 62'd0, 16'd20, 5'd4, 1'b1, 1'b0, 32'd9);
		add_insert(62'd2, 62'd0, 16'd20, 5'd4, 1'b0, 1'b0, 32'd9);
		add_request(16'd0);
		add_request(16'd13);
		add_request(16'd3);
		add_request(16'd100);
		add_request(16'hFFFF);
		add_request(16'd60);
		add_request(16'd30);
		add_request(16'hFFFF);
		add_request(16'hFFFF);
		add_request(16'hFFFF);
		// offset wrap on split remainder
		add_insert(62'd1, 62'h3FFF_FFFF_FFFF_FFFE, 16'd50, 5'd2, 1'b1, 1'b0, 32'd1);
		add_request(16'd10);
		add_request(16'hFFFF);
		wait (pending_txns.size() == 0 && expected_segs.size() == 0);

		// fill past capacity while the receiver holds off
		for (int i = 0; i < 70; i++) add_random_insert(300);
		add_request(16'hFFFF);
		for (int i = 0; i < 30; i++) add_request(16'($urandom_range(0, 400)));
		hold_off = 1'b1;
		repeat (3000) @(posedge clk);
		hold_off = 1'b0;
		wait (pending_txns.size() == 0 && expected_segs.size() == 0);

		// random mix
		for (int i = 0; i < 330; i++) begin
			if ($urandom_range(0, 2) != 0) add_random_insert($urandom_range(0, 9) == 0 ? 65535 : 600);
			else add_request($urandom_range(0, 9) == 0 ? 16'($urandom()) :
				16'($urandom_range(0, 1200)));
		end
		add_request(16'hFFFF);
		add_request(16'hFFFF);
		wait (pending_txns.size() == 0 && !s_axis_tvalid);
		wait (expected_segs.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && expected_segs.size() == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule

>>> priority_segment_packer_core.f
design/psp_pkg.sv
design/psp_datapath.sv
design/psp_ctrl.sv
design/priority_segment_packer_core.sv
verif/tb.sv
